[hw/rtl/mta_pkg.sv]
package mta_pkg;

  localparam int unsigned IDX_W  = 13;
  localparam int unsigned CRD_W  = 16;
  localparam int unsigned AREA_W = 36;

  localparam logic REQ_LOAD     = 1'b0;
  localparam logic REQ_TRIANGLE = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic [IDX_W-1:0]        vertex_index;
    logic signed [CRD_W-1:0] coord_x;
    logic signed [CRD_W-1:0] coord_y;
    logic signed [CRD_W-1:0] coord_z;
    logic [IDX_W-1:0]        corner_a;
    logic [IDX_W-1:0]        corner_b;
    logic [IDX_W-1:0]        corner_c;
  } req_t;

  typedef struct packed {
    logic [AREA_W-1:0] double_area;
    logic              index_invalid;
  } res_t;

  typedef enum logic [1:0] {
    CORNER_A = 2'd0,
    CORNER_B = 2'd1,
    CORNER_C = 2'd2
  } corner_e;

  // Operand selection for the shared multiplier.
  typedef enum logic [2:0] {
    MUL_NONE = 3'd0,
    MUL_CR_P = 3'd1,
    MUL_CR_Q = 3'd2,
    MUL_LL   = 3'd3,
    MUL_HL   = 3'd4,
    MUL_HH   = 3'd5
  } mul_sel_e;

  // What happens to the product registered in the previous cycle, or, for OP_ABS, to the cross component.
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_CR_LOAD = 3'd1,
    OP_CR_SUB  = 3'd2,
    OP_ABS     = 3'd3,
    OP_ADD_LL  = 3'd4,
    OP_ADD_HL  = 3'd5,
    OP_ADD_HH  = 3'd6
  } post_op_e;

  typedef struct packed {
    logic      load;
    logic      capture;
    corner_e   rd_corner;
    logic      latch_a;
    logic      latch_b;
    logic      form_edges;
    mul_sel_e  mul_sel;
    logic [1:0] comp;
    post_op_e  post_op;
    logic      root_step;
    logic      emit;
  } cmd_t;

  typedef struct packed {
    logic bad;
  } sts_t;

endpackage

[hw/rtl/mesh_triangle_area_unit.sv]
// Twice the area of a triangle taken from a stored vertex table. A load word
// (req_type 0) writes one vertex in the cycle it is accepted and leaves busy
// low, so loads stream at one per cycle while no triangle is in progress. A
// triangle word raises busy for three reads through the one read port of the
// vertex RAM, 24 steps of the one shared multiplier that forms the cross
// product and squares its components, and the square root, which settles one
// root bit per cycle. A triangle naming a corner of zero or above the highest
// slot loaded goes from the index check straight to the done state, skipping
// the arithmetic, and returns zero with index_invalid set. The result word
// appears on result_o with result_valid_o for a single cycle, the cycle after
// busy falls, and cannot be held back, so the receiver must take it then. The
// vertex table is not cleared by reset: a slot must be loaded before it is
// read.
module mesh_triangle_area_unit #(
  parameter int VERTICES   = 4096,
  parameter int COORD_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  mta_pkg::req_t req_i,
  output logic          result_valid_o,
  output mta_pkg::res_t result_o
);

  mta_pkg::cmd_t cmd;
  mta_pkg::sts_t sts;

  mta_ctrl #(
    .COORD_BITS(COORD_BITS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .req_type_i(req_i.req_type),
    .sts_i     (sts),
    .busy_o    (busy),
    .cmd_o     (cmd)
  );

  mta_dp #(
    .VERTICES  (VERTICES),
    .COORD_BITS(COORD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe lasted more than one cycle");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while a triangle is in progress");

  a_load_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.req_type == mta_pkg::REQ_LOAD) |=> !busy)
    else $error("load word raised busy");

  a_tri_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.req_type == mta_pkg::REQ_TRIANGLE) |=> busy)
    else $error("triangle word did not raise busy");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.index_invalid) |-> (result_o.double_area == '0))
    else $error("invalid triangle returned a non-zero area");

endmodule

[hw/rtl/mta_ram.sv]
module mta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/mta_ctrl.sv]
module mta_ctrl #(
  parameter int COORD_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          req_type_i,
  input  mta_pkg::sts_t sts_i,
  output logic          busy_o,
  output mta_pkg::cmd_t cmd_o
);

  localparam int RW  = 2 * COORD_BITS + 2;
  localparam int RCW = $clog2(RW);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_CHECK = 9'b000000010,
    ST_RD_B  = 9'b000000100,
    ST_RD_C  = 9'b000001000,
    ST_EDGE  = 9'b000010000,
    ST_MAC   = 9'b000100000,
    ST_ROOT  = 9'b001000000,
    ST_DONE  = 9'b010000000,
    ST_SPARE = 9'b100000000
  } state_e;

  state_e         state_q, state_d;
  logic [2:0]     step_q, step_d;
  logic [1:0]     comp_q, comp_d;
  logic [RCW-1:0] rcnt_q, rcnt_d;
  mta_pkg::cmd_t  cmd;

  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    comp_d        = comp_q;
    rcnt_d        = rcnt_q;
    cmd           = '0;
    cmd.rd_corner = mta_pkg::CORNER_A;
    cmd.mul_sel   = mta_pkg::MUL_NONE;
    cmd.post_op   = mta_pkg::OP_NONE;
    cmd.comp      = comp_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (req_type_i == mta_pkg::REQ_TRIANGLE) begin
            cmd.capture = 1'b1;
            state_d     = ST_CHECK;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        cmd.rd_corner = mta_pkg::CORNER_A;
        state_d       = sts_i.bad ? ST_DONE : ST_RD_B;
      end
      ST_RD_B: begin
        cmd.rd_corner = mta_pkg::CORNER_B;
        cmd.latch_a   = 1'b1;
        state_d       = ST_RD_C;
      end
      ST_RD_C: begin
        cmd.rd_corner = mta_pkg::CORNER_C;
        cmd.latch_b   = 1'b1;
        state_d       = ST_EDGE;
      end
      ST_EDGE: begin
        cmd.form_edges = 1'b1;
        step_d         = 3'd0;
        comp_d         = 2'd0;
        state_d        = ST_MAC;
      end
      ST_MAC: begin
        // Each cross component takes eight steps: two products and a
        // subtraction, the magnitude, then three partial squares summed.
        unique case (step_q)
          3'd0: cmd.mul_sel = mta_pkg::MUL_CR_P;
          3'd1: begin
            cmd.mul_sel = mta_pkg::MUL_CR_Q;
            cmd.post_op = mta_pkg::OP_CR_LOAD;
          end
          3'd2: cmd.post_op = mta_pkg::OP_CR_SUB;
          3'd3: cmd.post_op = mta_pkg::OP_ABS;
          3'd4: cmd.mul_sel = mta_pkg::MUL_LL;
          3'd5: begin
            cmd.mul_sel = mta_pkg::MUL_HL;
            cmd.post_op = mta_pkg::OP_ADD_LL;
          end
          3'd6: begin
            cmd.mul_sel = mta_pkg::MUL_HH;
            cmd.post_op = mta_pkg::OP_ADD_HL;
          end
          default: cmd.post_op = mta_pkg::OP_ADD_HH;
        endcase
        if (step_q == 3'd7) begin
          step_d = 3'd0;
          if (comp_q == 2'd2) begin
            rcnt_d  = '0;
            state_d = ST_ROOT;
          end else begin
            comp_d = comp_q + 2'd1;
          end
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (rcnt_q == RCW'(RW - 1)) begin
          state_d = ST_DONE;
        end else begin
          rcnt_d = rcnt_q + 1'b1;
        end
      end
      ST_DONE: begin
        cmd.emit = 1'b1;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      comp_q  <= '0;
      rcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      comp_q  <= comp_d;
      rcnt_q  <= rcnt_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign cmd_o  = cmd;

endmodule

[hw/rtl/mta_dp.sv]
module mta_dp #(
  parameter int VERTICES   = 4096,
  parameter int COORD_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mta_pkg::req_t req_i,
  input  mta_pkg::cmd_t cmd_i,
  output mta_pkg::sts_t sts_o,
  output logic          result_valid_o,
  output mta_pkg::res_t result_o
);

  localparam int CB   = COORD_BITS;
  localparam int EW   = CB + 1;
  localparam int MOW  = CB + 2;
  localparam int PW   = 2 * MOW;
  localparam int CW   = 2 * CB + 2;
  localparam int MW   = 2 * CB + 1;
  localparam int HW   = CB + 1;
  localparam int ACCW = 2 * MW + 2;
  localparam int RW   = ACCW / 2;
  localparam int AW   = $clog2(VERTICES);
  localparam int VW   = 3 * CB;
  localparam int IW   = mta_pkg::IDX_W;

  logic [IW-1:0]        ca_q, cb_q, cc_q, highest_q;
  logic [VW-1:0]        va_q, vb_q, rdata;
  logic signed [CB-1:0] va_s [3];
  logic signed [CB-1:0] vb_s [3];
  logic signed [CB-1:0] vc_s [3];
  logic signed [EW-1:0] e1_q [3];
  logic signed [EW-1:0] e2_q [3];
  logic signed [MOW-1:0] op_a, op_b;
  logic signed [PW-1:0] product, p_q;
  logic [PW-1:0]        p_u;
  logic signed [CW-1:0] cr_q;
  logic [CW-1:0]        cr_abs;
  logic [MW-1:0]        m_q;
  logic [HW-1:0]        m_lo;
  logic [MW-HW-1:0]     m_hi;
  logic [ACCW-1:0]      acc_q;
  logic [RW+1:0]        rem_q;
  logic [RW-1:0]        root_q;
  logic [RW+3:0]        remx, trial, diff;
  logic                 take;
  logic [1:0]           i1, i2;
  logic [31:0]          slot_ext, waddr_full, raddr_full;
  logic [IW-1:0]        rd_idx;
  logic                 slot_ok, we;
  logic                 bad;
  mta_pkg::res_t        res_q;
  logic                 valid_q;

  // Vertex table write: slots outside one to VERTICES are dropped.
  assign slot_ext   = 32'(req_i.vertex_index);
  assign slot_ok    = (req_i.vertex_index != '0) && (slot_ext <= 32'(VERTICES));
  assign we         = cmd_i.load && slot_ok;
  assign waddr_full = slot_ext - 32'd1;

  always_comb begin
    case (cmd_i.rd_corner)
      mta_pkg::CORNER_B: rd_idx = cb_q;
      mta_pkg::CORNER_C: rd_idx = cc_q;
      default:           rd_idx = ca_q;
    endcase
  end
  assign raddr_full = 32'(rd_idx) - 32'd1;

  mta_ram #(
    .WIDTH(VW),
    .DEPTH(VERTICES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr_full[AW-1:0]),
    .wdata_i({req_i.coord_z[CB-1:0], req_i.coord_y[CB-1:0], req_i.coord_x[CB-1:0]}),
    .raddr_i(raddr_full[AW-1:0]),
    .rdata_o(rdata)
  );

  assign bad = (ca_q == '0) || (ca_q > highest_q) ||
               (cb_q == '0) || (cb_q > highest_q) ||
               (cc_q == '0) || (cc_q > highest_q);
  assign sts_o.bad = bad;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      va_s[j] = va_q[j*CB +: CB];
      vb_s[j] = vb_q[j*CB +: CB];
      vc_s[j] = rdata[j*CB +: CB];
    end
  end

  // Component i of the cross product is e1[i+1]*e2[i+2] - e1[i+2]*e2[i+1].
  always_comb begin
    case (cmd_i.comp)
      2'd0:    begin i1 = 2'd1; i2 = 2'd2; end
      2'd1:    begin i1 = 2'd2; i2 = 2'd0; end
      default: begin i1 = 2'd0; i2 = 2'd1; end
    endcase
  end

  // The magnitude is squared as high and low halves to keep the multiplier narrow.
  assign m_lo = m_q[HW-1:0];
  assign m_hi = m_q[MW-1:HW];

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (cmd_i.mul_sel)
      mta_pkg::MUL_CR_P: begin
        op_a = MOW'(e1_q[i1]);
        op_b = MOW'(e2_q[i2]);
      end
      mta_pkg::MUL_CR_Q: begin
        op_a = MOW'(e1_q[i2]);
        op_b = MOW'(e2_q[i1]);
      end
      mta_pkg::MUL_LL: begin
        op_a = MOW'(m_lo);
        op_b = MOW'(m_lo);
      end
      mta_pkg::MUL_HL: begin
        op_a = MOW'(m_hi);
        op_b = MOW'(m_lo);
      end
      mta_pkg::MUL_HH: begin
        op_a = MOW'(m_hi);
        op_b = MOW'(m_hi);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign product = op_a * op_b;
  assign p_u     = p_q;
  assign cr_abs  = cr_q[CW-1] ? (~cr_q + 1'b1) : cr_q;

  // One bit of the root per cycle, two radicand bits shifted in each time.
  assign remx  = {rem_q, acc_q[ACCW-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign take  = (remx >= trial);
  assign diff  = remx - trial;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ca_q <= req_i.corner_a;
      cb_q <= req_i.corner_b;
      cc_q <= req_i.corner_c;
    end
    if (cmd_i.latch_a) begin
      va_q <= rdata;
    end
    if (cmd_i.latch_b) begin
      vb_q <= rdata;
    end
    p_q <= product;
    if (cmd_i.form_edges) begin
      for (int j = 0; j < 3; j++) begin
        e1_q[j] <= EW'(vb_s[j]) - EW'(va_s[j]);
        e2_q[j] <= EW'(vc_s[j]) - EW'(va_s[j]);
      end
      acc_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      acc_q  <= acc_q << 2;
      rem_q  <= take ? diff[RW+1:0] : remx[RW+1:0];
      root_q <= {root_q[RW-2:0], take};
    end else begin
      unique case (cmd_i.post_op)
        mta_pkg::OP_CR_LOAD: cr_q  <= signed'(p_q[CW-1:0]);
        mta_pkg::OP_CR_SUB:  cr_q  <= cr_q - signed'(p_q[CW-1:0]);
        mta_pkg::OP_ABS:     m_q   <= cr_abs[MW-1:0];
        mta_pkg::OP_ADD_LL:  acc_q <= acc_q + ACCW'(p_u);
        mta_pkg::OP_ADD_HL:  acc_q <= acc_q + (ACCW'(p_u) << (HW + 1));
        mta_pkg::OP_ADD_HH:  acc_q <= acc_q + (ACCW'(p_u) << (2 * HW));
        default: ;
      endcase
    end
    if (cmd_i.emit) begin
      res_q.double_area   <= bad ? '0 : mta_pkg::AREA_W'(root_q);
      res_q.index_invalid <= bad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      highest_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      if (we && (req_i.vertex_index > highest_q)) begin
        highest_q <= req_i.vertex_index;
      end
      valid_q <= cmd_i.emit;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule
